// ----- rtl/shef_pkg.sv -----
// shef_pkg: shared types, constants and arithmetic helpers for the
// horizontal sobel edge filter core; used by every module in rtl/
`default_nettype none

package shef_pkg;

    // register indexes on the configuration port
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // operation codes of an input beat
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam int          MAX_WIDTH_DEF = 256;
    localparam logic [8:0]  DIM_RESET     = 9'd256;
    localparam logic [8:0]  DIM_MIN       = 9'd2;
    localparam logic [7:0]  SAT_MAX       = 8'd255;
    localparam int          QUEUE_DEPTH   = 8;

    typedef struct packed {
        logic       operation;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       run_last;
        logic       frame_last;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_pixel;

    // 1,2,1 weighted column sum per channel
    typedef struct packed {
        logic [9:0] r;
        logic [9:0] g;
        logic [9:0] b;
    } t_csum;

    typedef struct packed {
        logic load;
        logic clear;
    } t_cell_ctl;

    // two implies one
    typedef struct packed {
        logic one;
        logic two;
    } t_push;

    function automatic logic [9:0] wsum(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return 10'(a) + {1'b0, b, 1'b0} + 10'(c);
    endfunction

    function automatic t_csum col_sum(input t_pixel top, input t_pixel mid,
                                      input t_pixel bot);
        t_csum s;
        s.r = wsum(top.r, mid.r, bot.r);
        s.g = wsum(top.g, mid.g, bot.g);
        s.b = wsum(top.b, mid.b, bot.b);
        return s;
    endfunction

    function automatic logic [7:0] sat_abs_diff(input logic [9:0] a, input logic [9:0] b);
        logic [10:0] d;
        logic [9:0]  m;
        d = {1'b0, a} - {1'b0, b};
        m = d[10] ? 10'(~d + 11'd1) : d[9:0];
        return (m > 10'(SAT_MAX)) ? SAT_MAX : m[7:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sobel_horizontal_edge_filter_core.sv -----
// sobel_horizontal_edge_filter_core: streaming 3x3 horizontal sobel magnitude on rgb
// depends on shef_pkg, shef_line_store, shef_col_cell, shef_out_queue
//
//   port group   direction  handshake                    beat
//   input        in         i_in_valid / o_in_stall      shef_pkg::t_in_beat
//   output       out        o_out_valid / i_out_stall    shef_pkg::t_out_beat
//   config       in         i_cfg_we, i_cfg_index        i_cfg_data (9 bits)
//
// one input beat per cycle while o_in_stall is low; its results enter the 8-entry output
// queue after the registered steps (line store read, then the column cell row)
// a row end item gives two results, the column-zero item none, so one beat a cycle
// is kept up; the queue credit check sets o_in_stall
// line stores need no clearing pass: they are masked on the first two rows
// reset is synchronous; a register write restarts the frame at pixel (0,0)
`default_nettype none

module sobel_horizontal_edge_filter_core #(
    parameter int MAX_WIDTH = shef_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire shef_pkg::t_in_beat  i_in_beat,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output shef_pkg::t_out_beat      o_out_beat,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [8:0]          i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = $clog2(shef_pkg::QUEUE_DEPTH);
    localparam int CW = PW + 3;

    // configuration and stream position
    logic [8:0] r_image_width;
    logic [8:0] r_image_height;
    logic [8:0] r_col;
    logic [8:0] r_row;
    logic [8:0] w_eff;
    logic [8:0] h_eff;
    logic [8:0] x_cur;
    logic [8:0] y_cur;
    logic [9:0] x_inc;
    logic [9:0] y_inc;
    logic [8:0] n_col;
    logic [8:0] n_row;
    logic       accept;
    shef_pkg::t_pixel in_pix;

    // stage 1: line store read in flight
    logic             r_v1;
    logic [8:0]       r_x1;
    shef_pkg::t_pixel r_pix1;
    logic             r_top_ok1;
    logic             r_mid_ok1;
    logic             r_e1_1;
    logic             r_e2_1;
    logic             r_fl_1;
    shef_pkg::t_pixel rd_older;
    shef_pkg::t_pixel rd_newer;
    shef_pkg::t_pixel top_pix;
    shef_pkg::t_pixel mid_pix;
    shef_pkg::t_csum  new_sum;

    // stage 2: window ready in the cells
    logic r_v2;
    logic r_e1_2;
    logic r_e2_2;
    logic r_fl_2;

    shef_pkg::t_cell_ctl cell_ctl [3];
    shef_pkg::t_csum     cell_in  [3];
    shef_pkg::t_csum     cell_sum [3];

    shef_pkg::t_out_beat beat_a;
    shef_pkg::t_out_beat beat_b;
    shef_pkg::t_out_beat beat0;
    shef_pkg::t_push     push;
    logic [PW:0]         q_count;
    logic [CW-1:0]       need;

    always_comb begin
        w_eff = r_image_width;
        if (r_image_width < shef_pkg::DIM_MIN) begin
            w_eff = shef_pkg::DIM_MIN;
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_eff = 9'(MAX_WIDTH);
        end
        h_eff = (r_image_height < shef_pkg::DIM_MIN) ? shef_pkg::DIM_MIN : r_image_height;
    end

    always_comb begin
        if (r_col >= w_eff || r_row > h_eff) begin
            x_cur = '0;
            y_cur = '0;
        end else begin
            x_cur = r_col;
            y_cur = r_row;
        end
        x_inc = 10'(x_cur) + 10'd1;
        y_inc = 10'(y_cur) + 10'd1;
        n_col = x_inc[8:0];
        n_row = y_cur;
        if (x_inc >= 10'(w_eff)) begin
            n_col = '0;
            n_row = (y_inc > 10'(h_eff)) ? 9'd0 : y_inc[8:0];
        end
    end

    assign in_pix = (i_in_beat.operation == shef_pkg::OP_PIXEL && y_cur < h_eff)
                  ? {i_in_beat.red_in, i_in_beat.green_in, i_in_beat.blue_in}
                  : '0;

    // reserve two queue slots for every item in flight and for the new one
    assign need = CW'(q_count) + (r_v1 ? CW'(2) : CW'(0)) + (r_v2 ? CW'(2) : CW'(0))
                + CW'(2);
    assign o_in_stall = (need > CW'(shef_pkg::QUEUE_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= shef_pkg::DIM_RESET;
            r_image_height <= shef_pkg::DIM_RESET;
            r_col          <= '0;
            r_row          <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                shef_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data;
                end
                shef_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_e1_1 <= 1'b0;
            r_e2_1 <= 1'b0;
            r_fl_1 <= 1'b0;
            r_v2   <= 1'b0;
            r_e1_2 <= 1'b0;
            r_e2_2 <= 1'b0;
            r_fl_2 <= 1'b0;
        end else begin
            r_v1   <= accept;
            r_e1_1 <= accept && y_cur != '0 && x_cur != '0;
            r_e2_1 <= accept && y_cur != '0 && x_cur == w_eff - 9'd1;
            r_fl_1 <= accept && y_cur == h_eff;
            r_v2   <= r_v1;
            r_e1_2 <= r_e1_1;
            r_e2_2 <= r_e2_1;
            r_fl_2 <= r_fl_1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x1      <= x_cur;
            r_pix1    <= in_pix;
            r_top_ok1 <= (y_cur >= 9'd2);
            r_mid_ok1 <= (y_cur != '0);
        end
    end

    shef_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk      (i_clk),
        .i_rd_en    (accept),
        .i_rd_addr  (AW'(x_cur)),
        .o_older    (rd_older),
        .o_newer    (rd_newer),
        .i_wr_en    (r_v1),
        .i_wr_addr  (AW'(r_x1)),
        .i_wr_older (rd_newer),
        .i_wr_newer (r_pix1)
    );

    assign top_pix = r_top_ok1 ? rd_older : '0;
    assign mid_pix = r_mid_ok1 ? rd_newer : '0;
    assign new_sum = shef_pkg::col_sum(top_pix, mid_pix, r_pix1);

    // cell 0 is the left column, cell 2 the right one taking the fresh column
    genvar gi;
    generate
        for (gi = 0; gi < 3; gi++) begin : g_cell
            if (gi == 2) begin : g_right
                assign cell_in[gi]        = new_sum;
                assign cell_ctl[gi].clear = 1'b0;
            end else begin : g_shift
                assign cell_in[gi]        = cell_sum[gi+1];
                assign cell_ctl[gi].clear = (r_x1 == '0);
            end
            assign cell_ctl[gi].load = r_v1;

            shef_col_cell u_cell (
                .i_clk (i_clk),
                .i_ctl (cell_ctl[gi]),
                .i_sum (cell_in[gi]),
                .o_sum (cell_sum[gi])
            );
        end
    endgenerate

    always_comb begin
        beat_a.red_out    = shef_pkg::sat_abs_diff(cell_sum[2].r, cell_sum[0].r);
        beat_a.green_out  = shef_pkg::sat_abs_diff(cell_sum[2].g, cell_sum[0].g);
        beat_a.blue_out   = shef_pkg::sat_abs_diff(cell_sum[2].b, cell_sum[0].b);
        beat_a.run_last   = !r_e2_2;
        beat_a.frame_last = 1'b0;
        // right border: the column beyond the image is zero padding
        beat_b.red_out    = shef_pkg::sat_abs_diff(cell_sum[1].r, '0);
        beat_b.green_out  = shef_pkg::sat_abs_diff(cell_sum[1].g, '0);
        beat_b.blue_out   = shef_pkg::sat_abs_diff(cell_sum[1].b, '0);
        beat_b.run_last   = 1'b1;
        beat_b.frame_last = r_fl_2;
        beat0             = r_e1_2 ? beat_a : beat_b;
        push.one          = r_v2 && (r_e1_2 || r_e2_2);
        push.two          = r_v2 && r_e1_2 && r_e2_2;
    end

    shef_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_beat0 (beat0),
        .i_beat1 (beat_b),
        .o_valid (o_out_valid),
        .o_beat  (o_out_beat),
        .i_stall (i_out_stall),
        .o_count (q_count)
    );

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (CW'(q_count) + CW'(2) <= CW'(shef_pkg::QUEUE_DEPTH)))
        else $error("result queue short of room for a stage 2 item");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= (PW+1)'(shef_pkg::QUEUE_DEPTH))
        else $error("result queue count beyond depth");

    a_col0_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_x1 == '0) |-> !r_e1_1)
        else $error("window result flagged on column zero");

    a_frame_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.frame_last) |-> o_out_beat.run_last)
        else $error("frame end beat not marked as run end");

endmodule

`default_nettype wire

// ----- rtl/shef_col_cell.sv -----
// shef_col_cell: one window column of the 3x3 window, held as its weighted sums
// depends on shef_pkg
`default_nettype none

module shef_col_cell (
    input  wire logic               i_clk,
    input  wire shef_pkg::t_cell_ctl i_ctl,
    input  wire shef_pkg::t_csum    i_sum,
    output shef_pkg::t_csum         o_sum
);

    shef_pkg::t_csum r_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sum <= i_ctl.clear ? '0 : i_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

// ----- rtl/shef_line_store.sv -----
// shef_line_store: the two previous image rows, one memory each, registered read
// depends on shef_pkg
`default_nettype none

module shef_line_store #(
    parameter int DEPTH = shef_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output shef_pkg::t_pixel              o_older,
    output shef_pkg::t_pixel              o_newer,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire shef_pkg::t_pixel         i_wr_older,
    input  wire shef_pkg::t_pixel         i_wr_newer
);

    shef_pkg::t_pixel r_older_mem [DEPTH];
    shef_pkg::t_pixel r_newer_mem [DEPTH];
    shef_pkg::t_pixel r_older_q;
    shef_pkg::t_pixel r_newer_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_older_mem[i_wr_addr] <= i_wr_older;
            r_newer_mem[i_wr_addr] <= i_wr_newer;
        end
        if (i_rd_en) begin
            r_older_q <= r_older_mem[i_rd_addr];
            r_newer_q <= r_newer_mem[i_rd_addr];
        end
    end

    assign o_older = r_older_q;
    assign o_newer = r_newer_q;

endmodule

`default_nettype wire

// ----- rtl/shef_out_queue.sv -----
// shef_out_queue: small result queue taking up to two beats a cycle
// depends on shef_pkg
`default_nettype none

module shef_out_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire shef_pkg::t_push      i_push,
    input  wire shef_pkg::t_out_beat  i_beat0,
    input  wire shef_pkg::t_out_beat  i_beat1,
    output logic                      o_valid,
    output shef_pkg::t_out_beat       o_beat,
    input  wire logic                 i_stall,
    output logic [$clog2(shef_pkg::QUEUE_DEPTH):0] o_count
);

    localparam int PW = $clog2(shef_pkg::QUEUE_DEPTH);

    shef_pkg::t_out_beat r_q [shef_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic [PW:0]   n_count;
    logic [PW-1:0] n_wr_ptr;
    logic          pop;

    assign pop = o_valid && !i_stall;

    always_comb begin
        n_count  = r_count - (PW+1)'(pop);
        n_wr_ptr = r_wr_ptr;
        if (i_push.one) begin
            n_count  = n_count + (PW+1)'(1);
            n_wr_ptr = r_wr_ptr + PW'(1);
        end
        if (i_push.two) begin
            n_count  = n_count + (PW+1)'(1);
            n_wr_ptr = r_wr_ptr + PW'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.one) begin
            r_q[r_wr_ptr] <= i_beat0;
        end
        if (i_push.two) begin
            r_q[r_wr_ptr + PW'(1)] <= i_beat1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_beat  = r_q[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ----- tb/tb_sobel_horizontal_edge_filter_core.sv -----
// testbench for the streaming horizontal sobel magnitude core: drives rgb frames,
// predicts every result beat with its own line stores and window, checks in order
// depends on shef_pkg and sobel_horizontal_edge_filter_core
module tb_sobel_horizontal_edge_filter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W        = shef_pkg::MAX_WIDTH_DEF;
    localparam int SETTLE       = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BEATS = 80;

    typedef shef_pkg::t_pixel [2:0] t_column;   // [0] top, [1] middle, [2] bottom

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    shef_pkg::t_in_beat  i_in_beat;
    logic                o_out_valid;
    logic                i_out_stall;
    shef_pkg::t_out_beat o_out_beat;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [8:0]          i_cfg_data;

    // predictor state
    shef_pkg::t_pixel    upper_row_px [MAX_W];
    shef_pkg::t_pixel    prev_row_px  [MAX_W];
    t_column             kernel_cols  [3];
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic [8:0]          cfg_width;
    logic [8:0]          cfg_height;
    shef_pkg::t_out_beat pending_gradients [$];

    bit sender_idles;
    bit receiver_idles;
    bit hold_requested;
    int hold_left;
    int fail_count;
    int beats_sent;
    int results_checked;
    int frames_done;
    int cfg_writes;

    sobel_horizontal_edge_filter_core #(
        .MAX_WIDTH (MAX_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [7:0] channel_gradient(input int l0, input int l1,
                                                    input int l2, input int r0,
                                                    input int r1, input int r2);
        int g;
        g = (r0 + 2 * r1 + r2) - (l0 + 2 * l1 + l2);
        if (g < 0) g = -g;
        if (g > 255) g = 255;
        return 8'(g);
    endfunction

    function automatic shef_pkg::t_out_beat gradient_of(input t_column lc, input t_column rc);
        shef_pkg::t_out_beat res;
        res = '0;
        res.red_out   = channel_gradient(lc[0].r, lc[1].r, lc[2].r,
                                         rc[0].r, rc[1].r, rc[2].r);
        res.green_out = channel_gradient(lc[0].g, lc[1].g, lc[2].g,
                                         rc[0].g, rc[1].g, rc[2].g);
        res.blue_out  = channel_gradient(lc[0].b, lc[1].b, lc[2].b,
                                         rc[0].b, rc[1].b, rc[2].b);
        return res;
    endfunction

    task automatic clear_predictor();
        for (int i = 0; i < MAX_W; i++) begin
            upper_row_px[i] = '0;
            prev_row_px[i]  = '0;
        end
        for (int i = 0; i < 3; i++) kernel_cols[i] = '0;
        col_pos    = 0;
        row_pos    = 0;
        cfg_width  = shef_pkg::DIM_RESET;
        cfg_height = shef_pkg::DIM_RESET;
        pending_gradients.delete();
    endtask

    task automatic predict_gradients(input shef_pkg::t_in_beat b);
        int unsigned         w, h, x, y;
        shef_pkg::t_pixel    pix, top, mid;
        shef_pkg::t_out_beat res [2];
        int                  n;
        w = cfg_width;
        if (w < 2) w = 2;
        if (w > MAX_W) w = MAX_W;
        h = cfg_height;
        if (h < 2) h = 2;
        x = col_pos;
        y = row_pos;
        if (x >= w || y > h) begin
            x = 0;
            y = 0;
        end
        // flush items and anything in the padding row count as black
        pix = (b.operation == shef_pkg::OP_PIXEL && y < h)
            ? {b.red_in, b.green_in, b.blue_in} : '0;
        top = (y >= 2) ? upper_row_px[x] : '0;
        mid = (y >= 1) ? prev_row_px[x] : '0;
        kernel_cols[0] = (x == 0) ? '0 : kernel_cols[1];
        kernel_cols[1] = (x == 0) ? '0 : kernel_cols[2];
        kernel_cols[2][0] = top;
        kernel_cols[2][1] = mid;
        kernel_cols[2][2] = pix;
        upper_row_px[x] = prev_row_px[x];
        prev_row_px[x]  = pix;
        n = 0;
        if (y >= 1 && x >= 1) begin
            res[n] = gradient_of(kernel_cols[0], kernel_cols[2]);
            n++;
        end
        // row end: right neighbour is the zero padding column
        if (y >= 1 && x == w - 1) begin
            res[n] = gradient_of(kernel_cols[1], '0);
            res[n].frame_last = (y == h);
            n++;
        end
        if (n > 0) res[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++) pending_gradients.push_back(res[i]);
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y > h) y = 0;
        end
        col_pos = x;
        row_pos = y;
    endtask

    task automatic compare_field(input string name, input logic [7:0] expv,
                                 input logic [7:0] actv);
        if (actv !== expv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            fail_count++;
        end
    endtask

    task automatic check_gradient(input shef_pkg::t_out_beat got);
        shef_pkg::t_out_beat want;
        if (pending_gradients.size() == 0) begin
            $error("result beat with nothing pending: %h", got);
            fail_count++;
        end else begin
            want = pending_gradients.pop_front();
            compare_field("red_out", want.red_out, got.red_out);
            compare_field("green_out", want.green_out, got.green_out);
            compare_field("blue_out", want.blue_out, got.blue_out);
            compare_field("run_last", 8'(want.run_last), 8'(got.run_last));
            compare_field("frame_last", 8'(want.frame_last), 8'(got.frame_last));
            results_checked++;
        end
    endtask

    // predict before checking: a beat's results never leave in its own cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_predictor();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == shef_pkg::REG_IMAGE_WIDTH) cfg_width = i_cfg_data;
                else cfg_height = i_cfg_data;
                col_pos = 0;
                row_pos = 0;
            end
            if (i_in_valid && !o_in_stall) predict_gradients(i_in_beat);
            if (o_out_valid && !i_out_stall) check_gradient(o_out_beat);
        end
    end

    // receiver: random stalls, or one long hold-off on request
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_requested) begin
                hold_left      = HOLD_CYCLES;
                hold_requested = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= receiver_idles && ($urandom_range(99) < 26);
            end
        end
    end

    function automatic shef_pkg::t_in_beat beat_of(input logic op, input logic [7:0] r,
                                                   input logic [7:0] g, input logic [7:0] b);
        shef_pkg::t_in_beat bt;
        bt.operation = op;
        bt.red_in    = r;
        bt.green_in  = g;
        bt.blue_in   = b;
        return bt;
    endfunction

    // channels lean towards the rails so the clamp gets plenty of work
    function automatic logic [7:0] random_channel();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_beat(input shef_pkg::t_in_beat b);
        while (sender_idles && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_gradients.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] val);
        wait_for_results();
        // a column-zero beat may still be in flight with nothing pending
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    // one frame of h image rows and the padding row; stop_at cuts it short,
    // pause_at lets the output drain before that beat
    task automatic send_frame(input int w, input int h, input int noise_pct,
                              input int stop_at, input int pause_at);
        shef_pkg::t_in_beat b;
        int                 idx;
        for (int y = 0; y <= h; y++) begin
            for (int x = 0; x < w; x++) begin
                idx = y * w + x;
                if (idx == stop_at) return;
                if (idx == pause_at) wait_for_results();
                b.operation = (y < h) ? shef_pkg::OP_PIXEL : shef_pkg::OP_FLUSH;
                if ($urandom_range(99) < noise_pct)
                    b.operation = (b.operation == shef_pkg::OP_PIXEL)
                                ? shef_pkg::OP_FLUSH : shef_pkg::OP_PIXEL;
                b.red_in   = random_channel();
                b.green_in = random_channel();
                b.blue_in  = random_channel();
                send_beat(b);
            end
        end
        frames_done++;
    endtask

    task automatic test_reset_geometry();
        // reset size is 256 x 256: the wrap into row one starts the first row's results
        send_frame(256, 256, 0, 260, -1);
    endtask

    task automatic test_directed_patterns();
        write_reg(shef_pkg::REG_IMAGE_WIDTH, 9'd4);
        write_reg(shef_pkg::REG_IMAGE_HEIGHT, 9'd2);
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF));
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00));
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF));
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00));
        // flush inside the image: data must read as zero
        send_beat(beat_of(shef_pkg::OP_FLUSH, 8'hFF, 8'hFF, 8'hFF));
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'h80, 8'h01, 8'hFE));
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'h7F));
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'h00, 8'hFF, 8'h80));
        // padding row, pixel beats here are ignored
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF));
        send_beat(beat_of(shef_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00));
        send_beat(beat_of(shef_pkg::OP_FLUSH, 8'hAA, 8'h55, 8'hAA));
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'h7F, 8'h80, 8'h01));
        // frame wrap with no write: old rows must stay masked
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00));
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00));
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00));
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00));
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'hFF));
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'h00, 8'hFF, 8'h00));
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF));
        send_beat(beat_of(shef_pkg::OP_PIXEL, 8'h01, 8'h02, 8'h03));
        send_beat(beat_of(shef_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00));
        send_beat(beat_of(shef_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00));
        send_beat(beat_of(shef_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00));
        send_beat(beat_of(shef_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00));
        frames_done += 2;
    endtask

    task automatic test_size_limits();
        // register values below the minimum behave as 2
        write_reg(shef_pkg::REG_IMAGE_WIDTH, 9'd0);
        write_reg(shef_pkg::REG_IMAGE_HEIGHT, 9'd1);
        send_frame(2, 2, 0, -1, -1);
        write_reg(shef_pkg::REG_IMAGE_WIDTH, 9'd1);
        write_reg(shef_pkg::REG_IMAGE_HEIGHT, 9'd0);
        send_frame(2, 2, 20, -1, -1);
        send_frame(2, 2, 0, -1, -1);
        // width above the line store size is held at 256
        write_reg(shef_pkg::REG_IMAGE_WIDTH, 9'd400);
        write_reg(shef_pkg::REG_IMAGE_HEIGHT, 9'd3);
        send_frame(MAX_W, 3, 0, MAX_W + 3, -1);
        write_reg(shef_pkg::REG_IMAGE_WIDTH, 9'd2);
        write_reg(shef_pkg::REG_IMAGE_HEIGHT, 9'd511);
        send_frame(2, 511, 5, 20, -1);
        write_reg(shef_pkg::REG_IMAGE_WIDTH, 9'd3);
        write_reg(shef_pkg::REG_IMAGE_HEIGHT, 9'd256);
        send_frame(3, 256, 0, 20, -1);
    endtask

    task automatic test_back_to_back();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        write_reg(shef_pkg::REG_IMAGE_WIDTH, 9'd6);
        write_reg(shef_pkg::REG_IMAGE_HEIGHT, 9'd3);
        repeat (3) send_frame(6, 3, 0, -1, -1);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    task automatic test_output_hold_off();
        sender_idles = 1'b0;
        write_reg(shef_pkg::REG_IMAGE_WIDTH, 9'd8);
        write_reg(shef_pkg::REG_IMAGE_HEIGHT, 9'd3);
        hold_requested = 1'b1;
        send_frame(8, 3, 0, -1, -1);
        sender_idles = 1'b1;
    endtask

    task automatic test_drain_mid_frame();
        write_reg(shef_pkg::REG_IMAGE_WIDTH, 9'd7);
        write_reg(shef_pkg::REG_IMAGE_HEIGHT, 9'd3);
        send_frame(7, 3, 10, -1, 12);
    endtask

    task automatic test_random_frames();
        int         start, w, h, noise, stop_at, pause_at;
        logic [8:0] wv, hv;
        bit         need_write;
        start      = beats_sent;
        need_write = 1'b1;
        w          = 2;
        h          = 2;
        while (beats_sent - start < RANDOM_BEATS) begin
            if (need_write || $urandom_range(9) < 7) begin
                w  = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 2);
                h  = $urandom_range(6, 2);
                wv = (w == 2 && $urandom_range(1)) ? 9'($urandom_range(1)) : 9'(w);
                hv = (h == 2 && $urandom_range(1)) ? 9'($urandom_range(1)) : 9'(h);
                write_reg(shef_pkg::REG_IMAGE_WIDTH, wv);
                write_reg(shef_pkg::REG_IMAGE_HEIGHT, hv);
                need_write = 1'b0;
            end
            noise    = ($urandom_range(3) == 0) ? $urandom_range(30, 5) : 0;
            stop_at  = ($urandom_range(7) == 0) ? $urandom_range((h + 1) * w - 1, 1) : -1;
            pause_at = ($urandom_range(9) == 0) ? $urandom_range((h + 1) * w - 1, 1) : -1;
            send_frame(w, h, noise, stop_at, pause_at);
            // a cut frame needs a write to restart at the top left
            if (stop_at >= 0) need_write = 1'b1;
        end
    endtask

    initial begin
        int guard;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_in_beat      <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= shef_pkg::REG_IMAGE_WIDTH;
        i_cfg_data     <= '0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        hold_requested = 1'b0;
        hold_left      = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_geometry();
        test_directed_patterns();
        test_size_limits();
        test_back_to_back();
        test_output_hold_off();
        test_drain_mid_frame();
        test_random_frames();

        i_in_valid <= 1'b0;
        for (guard = 0; guard < 20000 && pending_gradients.size() != 0; guard++)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (pending_gradients.size() != 0) begin
            $error("%0d result beats never arrived", pending_gradients.size());
            fail_count++;
        end

        $display("run covered %0d input beats, %0d result beats, %0d whole frames",
                 beats_sent, results_checked, frames_done);
        $display("with %0d register writes, widths 2..256 and heights 2..511, stalls on both sides",
                 cfg_writes);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
